FILE: rtl/ptacc_pkg.sv
package ptacc_pkg;

	// Defaults for the top-level parameters.
	localparam int WAVE_DEPTH_DEF     = 16384;
	localparam int TEMPLATE_DEPTH_DEF = 1024;
	localparam int MAX_RANGES_DEF     = 16;

	// Request codes carried in s_tuser.
	localparam logic [2:0] REQ_LOAD  = 3'd0;
	localparam logic [2:0] REQ_PULSE = 3'd1;
	localparam logic [2:0] REQ_READ  = 3'd2;
	localparam logic [2:0] REQ_CLEAR = 3'd3;
	localparam logic [2:0] REQ_DUMP  = 3'd4;

	// Configuration register indexes.
	localparam logic [1:0] CFG_N_SAMPLES  = 2'd0;
	localparam logic [1:0] CFG_PAD_TICKS  = 2'd1;
	localparam logic [1:0] CFG_TPL_LENGTH = 2'd2;
	localparam logic [1:0] CFG_PEDESTAL   = 2'd3;

	// Result kinds carried in m_tuser.
	localparam logic KIND_SAMPLE = 1'b0;
	localparam logic KIND_RANGE  = 1'b1;

	// Result word, lowest field last.
	typedef struct packed {
		logic [1:0]  fill;
		logic        overflow;
		logic        range_valid;
		logic [13:0] range_end;
		logic [13:0] range_start;
		logic [15:0] sample_value;
	} out_word_t;

	// Request word, lowest field last.
	typedef struct packed {
		logic [1:0]  scale;
		logic [15:0] template_value;
		logic [13:0] index;
	} in_word_t;

endpackage

FILE: rtl/ptacc_ram.sv
module ptacc_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 1024
) (
	input  logic                                   clk,
	input  logic                                   we,
	input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  logic [WIDTH-1:0]                       wdata,
	input  logic                                   re,
	input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic [WIDTH-1:0]                       rdata
);

	logic [WIDTH-1:0] mem [0:DEPTH-1];

	// One write port, one registered read port; read data holds between reads.
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

FILE: rtl/pulse_template_accumulator_top.sv
// Channel   Dir  Handshake          Payload
// s_*       in   s_tvalid/s_tready  tuser: req_type; tdata: index, template_value, scale
// m_*       out  m_tvalid/m_tready  tuser: kind; tdata: result word; tlast: last
// cfg_*     in   cfg_we             cfg_index selects register, cfg_data is the value
//
// A load is done on the accepting edge; a read, a clear, a pulse and a dump hold s_tready
// low until they finish. A pulse first clamps its span, then searches the range list
// and then walks the template through a read-modify-write of the wave memory; a pulse past
// the end or with an empty template returns to idle after the span check. A dump reads
// and sends each range in turn, or one empty word for an empty list. After reset the wave
// memory is swept to zero before the first word is taken.
// A stalled result holds the block at that result; one word is handled at a time.
module pulse_template_accumulator_top
	import ptacc_pkg::*;
#(
	parameter int WAVE_DEPTH     = WAVE_DEPTH_DEF,
	parameter int TEMPLATE_DEPTH = TEMPLATE_DEPTH_DEF,
	parameter int MAX_RANGES     = MAX_RANGES_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [31:0] s_tdata,  // index[13:0], template_value[29:14], scale[31:30]
	input  logic [2:0]  s_tuser,  // req_type[2:0]
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [47:0] m_tdata,  // sample_value[15:0], range_start[29:16],
	                              // range_end[43:30], range_valid[44], overflow[45]
	output logic        m_tuser,  // kind[0]
	output logic        m_tlast,
	input  logic        cfg_we,
	input  logic [1:0]  cfg_index,
	input  logic [15:0] cfg_data
);

	localparam int AW  = $clog2(WAVE_DEPTH);
	localparam int TAW = $clog2(TEMPLATE_DEPTH);
	localparam int EW  = (AW + 1 > 15) ? AW + 1 : 15;
	localparam int CW  = $clog2(MAX_RANGES + 1);
	localparam int RIW = (MAX_RANGES > 1) ? $clog2(MAX_RANGES) : 1;

	localparam logic [3:0] ST_IDLE     = 4'd0;
	localparam logic [3:0] ST_CLEAR    = 4'd1;
	localparam logic [3:0] ST_PREP     = 4'd2;
	localparam logic [3:0] ST_SPAN     = 4'd3;
	localparam logic [3:0] ST_SCAN_RD  = 4'd4;
	localparam logic [3:0] ST_SCAN_CMP = 4'd5;
	localparam logic [3:0] ST_WALK     = 4'd6;
	localparam logic [3:0] ST_RD_OUT   = 4'd7;
	localparam logic [3:0] ST_DUMP_RD  = 4'd8;
	localparam logic [3:0] ST_DUMP_OUT = 4'd9;

	in_word_t  in_w;
	out_word_t ow;

	logic [3:0]    state_q;
	logic [14:0]   n_samples_q;
	logic [9:0]    pad_q;
	logic [10:0]   tpl_len_q;
	logic [15:0]   pedestal_q;
	logic [CW-1:0] count_q;
	logic          ovf_q;
	logic [AW:0]   clr_q;
	logic [13:0]   index_q;
	logic [1:0]    scale_q;
	logic [EW-1:0] len_q;
	logic [EW-1:0] from_q;
	logic [EW-1:0] to_q;
	logic [EW-1:0] t_q;
	logic [CW-1:0] i_q;
	logic          valid_s1;
	logic [AW-1:0] waddr_s1;
	logic [1:0]    scale_s1;
	logic          m_tvalid_q;
	out_word_t     out_q;
	logic          kind_q;
	logic          last_q;

	logic [EW-1:0] eff_n, tick_e, tl_eff, room, to_sum, nm1, walk_tick;
	logic          s_acc, out_free, out_load;
	logic          tpl_we, wave_we, wave_re, rng_we, rng_re;
	logic [AW-1:0] wave_waddr, wave_raddr;
	logic [23:0]   wave_wdata, wave_rdata;
	logic [15:0]   tpl_rdata;
	logic [RIW-1:0] rng_waddr;
	logic [2*EW-1:0] rng_wdata, rng_rdata;
	logic [EW-1:0] rs, re_t;
	logic [17:0]   prod;
	logic [25:0]   acc_sum;
	logic [23:0]   acc_sat;
	logic [15:0]   q_val;
	logic          in_bound;

	assign in_w  = in_word_t'(s_tdata);
	assign s_tready = (state_q == ST_IDLE);
	assign s_acc = s_tvalid && s_tready;
	assign out_free = !m_tvalid_q || m_tready;

	// Effective register values after clamping.
	always_comb begin
		eff_n = EW'(n_samples_q);
		if (n_samples_q == 15'd0) begin
			eff_n = EW'(1);
		end else if (EW'(n_samples_q) > EW'(WAVE_DEPTH)) begin
			eff_n = EW'(WAVE_DEPTH);
		end
		tl_eff = (EW'(tpl_len_q) > EW'(TEMPLATE_DEPTH)) ? EW'(TEMPLATE_DEPTH) : EW'(tpl_len_q);
		tick_e = EW'(index_q);
		room   = eff_n - tick_e;
		nm1    = eff_n - EW'(1);
		to_sum = tick_e + len_q - EW'(1) + EW'(pad_q);
		walk_tick = tick_e + t_q;
	end

	// Range entry fields: start in the low half.
	assign rs   = rng_rdata[EW-1:0];
	assign re_t = rng_rdata[2*EW-1:EW];

	// Accumulate datapath for the word in stage one.
	always_comb begin
		prod    = $signed({16'd0, scale_s1}) * $signed({{2{tpl_rdata[15]}}, tpl_rdata});
		acc_sum = {{2{wave_rdata[23]}}, wave_rdata} + {{8{prod[17]}}, prod};
		if ($signed(acc_sum) > $signed(26'sd8388607)) begin
			acc_sat = 24'h7FFFFF;
		end else if ($signed(acc_sum) < -$signed(26'sd8388608)) begin
			acc_sat = 24'h800000;
		end else begin
			acc_sat = acc_sum[23:0];
		end
	end

	// Readout truncated toward zero.
	always_comb begin
		q_val = wave_rdata[23:8];
		if (wave_rdata[23] && (wave_rdata[7:0] != 8'd0)) begin
			q_val = wave_rdata[23:8] + 16'd1;
		end
		in_bound = (tick_e < eff_n);
	end

	// Memory port control.
	always_comb begin
		tpl_we     = s_acc && (s_tuser == REQ_LOAD) &&
		             ({1'b0, in_w.index} < 15'(TEMPLATE_DEPTH));
		wave_we    = 1'b0;
		wave_waddr = waddr_s1;
		wave_wdata = acc_sat;
		if (state_q == ST_CLEAR) begin
			wave_we    = (clr_q != (AW + 1)'(WAVE_DEPTH));
			wave_waddr = clr_q[AW-1:0];
			wave_wdata = {pedestal_q, 8'd0};
		end else if (valid_s1) begin
			wave_we = 1'b1;
		end
		wave_re    = 1'b0;
		wave_raddr = walk_tick[AW-1:0];
		if (s_acc && (s_tuser == REQ_READ)) begin
			wave_re    = 1'b1;
			wave_raddr = EW'(in_w.index) < EW'(WAVE_DEPTH) ?
			             in_w.index[AW-1:0] : '0;
		end else if ((state_q == ST_WALK) && (t_q < len_q)) begin
			wave_re = 1'b1;
		end
		rng_re = ((state_q == ST_SCAN_RD) && (i_q != count_q)) ||
		         ((state_q == ST_DUMP_RD) && (count_q != '0));
		rng_we    = 1'b0;
		rng_waddr = i_q[RIW-1:0];
		rng_wdata = {to_q, from_q};
		if ((state_q == ST_SCAN_RD) && (i_q == count_q) &&
		    (count_q < CW'(MAX_RANGES))) begin
			rng_we = 1'b1;
		end else if (state_q == ST_SCAN_CMP) begin
			if (!(from_q >= rs && to_q <= re_t)) begin
				if (from_q >= rs && from_q <= re_t) begin
					rng_we    = 1'b1;
					rng_wdata = {to_q, rs};
				end else if (to_q >= rs && to_q <= re_t) begin
					rng_we    = 1'b1;
					rng_wdata = {re_t, from_q};
				end
			end
		end
	end

	// Result word being loaded.
	always_comb begin
		out_load = 1'b0;
		ow       = '0;
		ow.overflow = ovf_q;
		if ((state_q == ST_RD_OUT) && out_free) begin
			out_load        = 1'b1;
			ow.sample_value = in_bound ? q_val : 16'd0;
		end else if ((state_q == ST_DUMP_RD) && (count_q == '0) && out_free) begin
			out_load = 1'b1;
		end else if ((state_q == ST_DUMP_OUT) && out_free) begin
			out_load       = 1'b1;
			ow.range_valid = 1'b1;
			ow.range_start = rs[13:0];
			ow.range_end   = re_t[13:0];
		end
	end

	ptacc_ram #(.WIDTH(16), .DEPTH(TEMPLATE_DEPTH)) u_tpl_ram (
		.clk   (clk),
		.we    (tpl_we),
		.waddr (in_w.index[TAW-1:0]),
		.wdata (in_w.template_value),
		.re    (wave_re && (state_q == ST_WALK)),
		.raddr (t_q[TAW-1:0]),
		.rdata (tpl_rdata)
	);

	ptacc_ram #(.WIDTH(24), .DEPTH(WAVE_DEPTH)) u_wave_ram (
		.clk   (clk),
		.we    (wave_we),
		.waddr (wave_waddr),
		.wdata (wave_wdata),
		.re    (wave_re),
		.raddr (wave_raddr),
		.rdata (wave_rdata)
	);

	ptacc_ram #(.WIDTH(2 * EW), .DEPTH(MAX_RANGES)) u_rng_ram (
		.clk   (clk),
		.we    (rng_we),
		.waddr (rng_waddr),
		.wdata (rng_wdata),
		.re    (rng_re),
		.raddr (i_q[RIW-1:0]),
		.rdata (rng_rdata)
	);

	// Configuration registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			n_samples_q <= 15'd16384;
			pad_q       <= '0;
			tpl_len_q   <= '0;
			pedestal_q  <= '0;
		end else if (cfg_we) begin
			case (cfg_index)
				CFG_N_SAMPLES:  n_samples_q <= cfg_data[14:0];
				CFG_PAD_TICKS:  pad_q       <= cfg_data[9:0];
				CFG_TPL_LENGTH: tpl_len_q   <= cfg_data[10:0];
				CFG_PEDESTAL:   pedestal_q  <= cfg_data;
				default: ;
			endcase
		end
	end

	// Sequencer.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= ST_CLEAR;
			clr_q    <= '0;
			count_q  <= '0;
			ovf_q    <= 1'b0;
			valid_s1 <= 1'b0;
			t_q      <= '0;
			i_q      <= '0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (s_acc) begin
						case (s_tuser)
							REQ_PULSE: state_q <= ST_PREP;
							REQ_READ:  state_q <= ST_RD_OUT;
							REQ_CLEAR: begin
								state_q <= ST_CLEAR;
								clr_q   <= '0;
								count_q <= '0;
								ovf_q   <= 1'b0;
							end
							REQ_DUMP: begin
								state_q <= ST_DUMP_RD;
								i_q     <= '0;
							end
							default: ;
						endcase
					end
				end
				ST_CLEAR: begin
					if (clr_q == (AW + 1)'(WAVE_DEPTH)) begin
						state_q <= ST_IDLE;
					end else begin
						clr_q <= clr_q + 1'b1;
					end
				end
				ST_PREP: begin
					if (tick_e >= eff_n || tl_eff == '0) begin
						state_q <= ST_IDLE;
					end else begin
						state_q <= ST_SPAN;
					end
				end
				ST_SPAN: begin
					state_q <= ST_SCAN_RD;
					i_q     <= '0;
					t_q     <= '0;
				end
				ST_SCAN_RD: begin
					if (i_q == count_q) begin
						if (count_q < CW'(MAX_RANGES)) begin
							count_q <= count_q + 1'b1;
						end else begin
							ovf_q <= 1'b1;
						end
						state_q <= ST_WALK;
					end else begin
						state_q <= ST_SCAN_CMP;
					end
				end
				ST_SCAN_CMP: begin
					if ((from_q >= rs && to_q <= re_t) ||
					    (from_q >= rs && from_q <= re_t) ||
					    (to_q >= rs && to_q <= re_t)) begin
						state_q <= ST_WALK;
					end else begin
						i_q     <= i_q + 1'b1;
						state_q <= ST_SCAN_RD;
					end
				end
				ST_WALK: begin
					valid_s1 <= (t_q < len_q);
					if (t_q < len_q) begin
						t_q <= t_q + 1'b1;
					end else if (!valid_s1) begin
						state_q <= ST_IDLE;
					end
				end
				ST_RD_OUT: begin
					if (out_free) begin
						state_q <= ST_IDLE;
					end
				end
				ST_DUMP_RD: begin
					if (count_q == '0) begin
						if (out_free) begin
							state_q <= ST_IDLE;
						end
					end else begin
						state_q <= ST_DUMP_OUT;
					end
				end
				ST_DUMP_OUT: begin
					if (out_free) begin
						i_q     <= i_q + 1'b1;
						state_q <= (i_q + 1'b1 == count_q) ? ST_IDLE : ST_DUMP_RD;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// Item and span registers.
	always_ff @(posedge clk) begin
		if (s_acc) begin
			index_q <= in_w.index;
			scale_q <= in_w.scale;
		end
		if (state_q == ST_PREP) begin
			len_q <= (tl_eff > room) ? room : tl_eff;
		end
		if (state_q == ST_SPAN) begin
			from_q <= (tick_e >= EW'(pad_q)) ? tick_e - EW'(pad_q) : '0;
			to_q   <= (to_sum > nm1) ? nm1 : to_sum;
		end
		waddr_s1 <= walk_tick[AW-1:0];
		scale_s1 <= scale_q;
	end

	// Output register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid_q <= 1'b0;
		end else if (out_load) begin
			m_tvalid_q <= 1'b1;
		end else if (m_tready) begin
			m_tvalid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			out_q  <= ow;
			kind_q <= (state_q == ST_RD_OUT) ? KIND_SAMPLE : KIND_RANGE;
			last_q <= (state_q != ST_DUMP_OUT) || (i_q + 1'b1 == count_q);
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = out_q;
	assign m_tuser  = kind_q;
	assign m_tlast  = last_q;

	// The walk never reads the sample it is writing back.
	a_no_rmw_clash: assert property (@(posedge clk) disable iff (!arst_n)
		(wave_we && wave_re) |-> (wave_waddr != wave_raddr))
		else $error("wave memory read and write hit one address");

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CW'(MAX_RANGES))
		else $error("range count beyond list size");

	a_ovf_full: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(ovf_q) |-> ($past(count_q) == CW'(MAX_RANGES)))
		else $error("overflow set with room in the list");

	a_load_free: assert property (@(posedge clk) disable iff (!arst_n)
		out_load |-> (!m_tvalid || m_tready))
		else $error("result overwritten before it was taken");

endmodule

FILE: verif/pulse_template_accumulator_top_test.sv
`timescale 1ns / 100ps

module pulse_template_accumulator_top_test;
	import ptacc_pkg::*;

	localparam int WAVE_N = 16384;
	localparam int TPL_N  = 1024;
	localparam int RNG_N  = 16;
	localparam int TPL_USED = 16;

	// One request word as the sender presents it.
	typedef struct {
		logic [2:0]         req;
		logic [13:0]        index;
		logic signed [15:0] tval;
		logic [1:0]         scale;
	} request_t;

	// One result word as the receiver should see it.
	typedef struct {
		logic               kind;
		logic signed [15:0] sample;
		logic [13:0]        rstart;
		logic [13:0]        rend;
		logic               rvalid;
		logic               ovf;
		logic               last;
	} readout_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        s_tvalid = 1'b0;
	logic        s_tready;
	logic [31:0] s_tdata = '0;
	logic [2:0]  s_tuser = '0;
	logic        m_tvalid;
	logic        m_tready = 1'b0;
	logic [47:0] m_tdata;
	logic        m_tuser;
	logic        m_tlast;
	logic        cfg_we = 1'b0;
	logic [1:0]  cfg_index = '0;
	logic [15:0] cfg_data = '0;

	pulse_template_accumulator_top i_dut (
		.clk(clk), .arst_n(arst_n),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser),
		.m_tlast(m_tlast),
		.cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
	);

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	// Shadow state of the accumulator.
	logic [15:0] tpl_mem [TPL_N];
	int          wave_mem [WAVE_N];
	int          span_lo [RNG_N];
	int          span_hi [RNG_N];
	int          span_count;
	logic        span_overflow;
	int          samples_reg;
	int          pad_reg;
	int          tpl_len_reg;
	int          pedestal_reg;

	request_t pending_words [$];
	readout_t expected_readouts [$];
	request_t cur_word;
	int       src_idle = 24;
	int       sink_idle = 66;
	int       mismatches = 0;
	int       words_sent = 0;
	int       readouts_seen = 0;

	function automatic int eff_samples();
		if (samples_reg < 1) return 1;
		if (samples_reg > WAVE_N) return WAVE_N;
		return samples_reg;
	endfunction

	function automatic void wipe_wave();
		for (int i = 0; i < WAVE_N; i++) wave_mem[i] = pedestal_reg * 256;
		span_count = 0;
		span_overflow = 1'b0;
	endfunction

	// Merge a touched span into the list of active ranges.
	function automatic void note_span(int first, int lst, int n);
		int lo;
		int hi;
		lo = first - pad_reg;
		hi = lst + pad_reg;
		if (lo < 0) lo = 0;
		if (hi > n - 1) hi = n - 1;
		for (int i = 0; i < span_count; i++) begin
			if (lo >= span_lo[i] && hi <= span_hi[i]) return;
			if (lo >= span_lo[i] && lo <= span_hi[i]) begin
				span_hi[i] = hi;
				return;
			end
			if (hi >= span_lo[i] && hi <= span_hi[i]) begin
				span_lo[i] = lo;
				return;
			end
		end
		if (span_count < RNG_N) begin
			span_lo[span_count] = lo;
			span_hi[span_count] = hi;
			span_count++;
		end else begin
			span_overflow = 1'b1;
		end
	endfunction

	function automatic void push_readout(logic kind, int sample, int rs, int re,
			logic valid, logic lst);
		readout_t r;
		r.kind = kind;
		r.sample = sample[15:0];
		r.rstart = rs[13:0];
		r.rend = re[13:0];
		r.rvalid = valid;
		r.ovf = span_overflow;
		r.last = lst;
		expected_readouts.insert(expected_readouts.size(), r);
	endfunction

	// Work out the effect of one accepted request word.
	function automatic void accumulate_word(request_t w);
		int n;
		int len;
		int v;
		n = eff_samples();
		case (w.req)
			REQ_LOAD: begin
				if (w.index < TPL_N) tpl_mem[w.index] = w.tval;
			end
			REQ_PULSE: begin
				len = (tpl_len_reg > TPL_N) ? TPL_N : tpl_len_reg;
				if (w.index < n && len != 0) begin
					if (len > n - w.index) len = n - w.index;
					note_span(w.index, w.index + len - 1, n);
					for (int t = 0; t < len; t++) begin
						v = wave_mem[w.index + t] + int'(w.scale) * int'($signed(tpl_mem[t]));
						if (v > 8388607) v = 8388607;
						if (v < -8388608) v = -8388608;
						wave_mem[w.index + t] = v;
					end
				end
			end
			REQ_READ: begin
				if (w.index >= n) begin
					v = 0;
				end else begin
					v = wave_mem[w.index] / 256;
					if (v > 32767) v = 32767;
					if (v < -32768) v = -32768;
				end
				push_readout(KIND_SAMPLE, v, 0, 0, 1'b0, 1'b1);
			end
			REQ_CLEAR: wipe_wave();
			REQ_DUMP: begin
				if (span_count == 0) push_readout(KIND_RANGE, 0, 0, 0, 1'b0, 1'b1);
				for (int i = 0; i < span_count; i++)
					push_readout(KIND_RANGE, 0, span_lo[i], span_hi[i], 1'b1,
						i == span_count - 1);
			end
			default: ;
		endcase
	endfunction

	// Sender: presents queued words and predicts each one on acceptance.
	always @(posedge clk) begin
		if (arst_n) begin
			if (s_tvalid && s_tready) begin
				accumulate_word(cur_word);
				words_sent++;
			end
			if (!s_tvalid || s_tready) begin
				if (pending_words.size() > 0 && $urandom_range(99) >= src_idle) begin
					cur_word = pending_words.pop_front();
					s_tvalid <= 1'b1;
					s_tuser <= cur_word.req;
					s_tdata <= {cur_word.scale, cur_word.tval, cur_word.index};
				end else begin
					s_tvalid <= 1'b0;
				end
			end
		end
	end

	// Receiver: checks each accepted result word against the oldest prediction.
	always @(posedge clk) begin
		readout_t e;
		if (arst_n) begin
			if (m_tvalid && m_tready) begin
				readouts_seen++;
				if (expected_readouts.size() == 0) begin
					mismatches++;
					if (mismatches <= 10)
						$display("Unexpected result word: tdata %h kind %b last %b",
							m_tdata, m_tuser, m_tlast);
				end else begin
					e = expected_readouts.pop_front();
					if (m_tuser !== e.kind || m_tdata[15:0] !== e.sample ||
							m_tdata[29:16] !== e.rstart || m_tdata[43:30] !== e.rend ||
							m_tdata[44] !== e.rvalid || m_tdata[45] !== e.ovf ||
							m_tlast !== e.last) begin
						mismatches++;
						if (mismatches <= 10)
							$display({"Mismatch: expected kind %b sample %0d range %0d..%0d ",
								"valid %b ovf %b last %b, got kind %b sample %0d ",
								"range %0d..%0d valid %b ovf %b last %b"},
								e.kind, e.sample, e.rstart, e.rend, e.rvalid, e.ovf,
								e.last, m_tuser, $signed(m_tdata[15:0]), m_tdata[29:16],
								m_tdata[43:30], m_tdata[44], m_tdata[45], m_tlast);
					end
				end
			end
			m_tready <= ($urandom_range(99) >= sink_idle);
		end
	end

	task automatic queue_word(logic [2:0] req, int idx, int tval, int scale);
		request_t w;
		w.req = req;
		w.index = idx[13:0];
		w.tval = tval[15:0];
		w.scale = scale[1:0];
		pending_words.insert(pending_words.size(), w);
	endtask

	// A dump closes every batch, so its results show that the block is idle.
	task automatic drain();
		queue_word(REQ_DUMP, 0, 0, 0);
		do @(negedge clk);
		while (pending_words.size() != 0 || s_tvalid || expected_readouts.size() != 0);
		repeat (8) @(posedge clk);
	endtask

	// Writes all four registers on consecutive edges while the block is idle.
	task automatic set_regs(int n, int pad, int len, int ped);
		int vals [4];
		vals = '{n, pad, len, ped};
		for (int i = 0; i < 4; i++) begin
			@(posedge clk);
			cfg_we <= 1'b1;
			cfg_index <= i[1:0];
			cfg_data <= vals[i][15:0];
		end
		@(posedge clk);
		cfg_we <= 1'b0;
		samples_reg = n & 16'h7fff;
		pad_reg = pad & 10'h3ff;
		tpl_len_reg = len & 11'h7ff;
		pedestal_reg = int'($signed(ped[15:0]));
	endtask

	// Random words: mostly pulses and reads inside the waveform, some noise.
	task automatic random_words(int count);
		int r;
		int idx;
		int n;
		for (int k = 0; k < count; k++) begin
			r = $urandom_range(99);
			n = eff_samples();
			idx = ($urandom_range(9) < 8) ? $urandom_range(n - 1) : $urandom_range(16383);
			if (r < 35)
				queue_word(REQ_PULSE, idx, $urandom, $urandom);
			else if (r < 70)
				queue_word(REQ_READ, idx, $urandom, $urandom);
			else if (r < 80)
				queue_word(REQ_LOAD, $urandom_range(16383), $urandom, $urandom);
			else if (r < 84)
				queue_word(REQ_CLEAR, $urandom, $urandom, $urandom);
			else if (r < 94)
				queue_word(REQ_DUMP, $urandom, $urandom, $urandom);
			else
				queue_word(3'($urandom_range(5, 7)), $urandom, $urandom, $urandom);
		end
	endtask

	initial begin
		samples_reg = WAVE_N;
		pad_reg = 0;
		tpl_len_reg = 0;
		pedestal_reg = 0;
		for (int i = 0; i < TPL_N; i++) tpl_mem[i] = '0;
		wipe_wave();
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;

		// Reset settings: empty template, reads and dumps of an empty list.
		// Only the template words that later pulses reach are loaded.
		queue_word(REQ_READ, 0, 0, 0);
		queue_word(REQ_READ, 16383, 0, 0);
		queue_word(REQ_PULSE, 0, 0, 3);
		queue_word(REQ_DUMP, 0, 0, 0);
		queue_word(REQ_LOAD, 0, 32767, 0);
		queue_word(REQ_LOAD, 1, -32768, 0);
		for (int i = 2; i < TPL_USED; i++) queue_word(REQ_LOAD, i, $urandom, $urandom);
		queue_word(REQ_LOAD, 1024, 0, 0);
		queue_word(REQ_LOAD, 16383, 0, 0);
		drain();

		// Overlapping, nested, clipped and zero-scale pulses.
		set_regs(16384, 0, 16, 0);
		queue_word(REQ_PULSE, 0, 0, 3);
		queue_word(REQ_PULSE, 8, 0, 1);
		queue_word(REQ_PULSE, 16383, 0, 2);
		queue_word(REQ_PULSE, 100, 0, 0);
		queue_word(REQ_PULSE, 90, 0, 1);
		queue_word(REQ_PULSE, 2, 0, 1);
		queue_word(REQ_READ, 0, 0, 0);
		queue_word(REQ_READ, 9, 0, 0);
		queue_word(REQ_READ, 16383, 0, 0);
		queue_word(REQ_READ, 100, 0, 0);
		queue_word(7, 5, 0, 0);
		random_words(10);
		drain();

		// One-tick waveform at the top pedestal with the longest template.
		set_regs(1, 1023, 1024, 32767);
		queue_word(REQ_CLEAR, 0, 0, 0);
		queue_word(REQ_PULSE, 0, 0, 3);
		queue_word(REQ_READ, 0, 0, 0);
		queue_word(REQ_READ, 1, 0, 0);
		queue_word(REQ_PULSE, 5, 0, 1);
		random_words(8);
		drain();

		// Bottom pedestal and more disjoint spans than the list holds.
		src_idle = 66;
		sink_idle = 24;
		set_regs(200, 3, 4, -32768);
		queue_word(REQ_CLEAR, 0, 0, 0);
		for (int i = 0; i < 17; i++) queue_word(REQ_PULSE, i * 12, 0, 1);
		queue_word(REQ_READ, 1, 0, 0);
		queue_word(REQ_DUMP, 0, 0, 0);
		random_words(10);
		drain();

		set_regs(5000, 10, TPL_USED, -100);
		queue_word(REQ_CLEAR, 0, 0, 0);
		random_words(12);
		drain();

		src_idle = 0;
		sink_idle = 0;
		set_regs(1024, 2, 8, 1);
		queue_word(REQ_CLEAR, 0, 0, 0);
		random_words(12);
		drain();

		repeat (20) @(posedge clk);
		$display("Covered %0d request words and %0d result words over six register settings,",
			words_sent, readouts_seen);
		$display("including saturation, clipped pulses and a full range list.");
		if (mismatches == 0 && expected_readouts.size() == 0) begin
			$display("All tests passed");
		end else begin
			$display("Some tests failed");
		end
		$finish;
	end

	initial begin
		#100ms;
		$display("Some tests failed");
		$finish;
	end

endmodule
